### hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the positional list engine.
// No dependencies; synthesis builds define SYNTHESIS and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge, off while reset is held.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ASSERT_PROP(lbl, clk, rstn, !(cond), msg)

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

### hw/rtl/plen_pkg.sv
// Shared constants and codes of the positional list engine.
// No dependencies.
package plen_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned LEN_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IN_W     = POS_W + DATA_W;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_DUMP   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

endpackage

### hw/rtl/positional_list_engine_core.sv
// Top level of the positional list engine: sequencer, length register, output stage.
// Depends on plen_pkg, plen_ram and assert_macros.svh.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------
//  s_axis  | in        | s_axis_tvalid/s_axis_tready | tuser req_type, tdata pos/value
//  m_axis  | out       | m_axis_tvalid/m_axis_tready | tuser status, tdata value, tlast
//
// An insert at p shifts the entries from p to the end up one place, a delete at p
// shifts the entries after p down one place, and a dump reads each entry in turn. The RAM read
// is registered, so each moved entry passes through a read state and then a write state.
// Reset clears the length and the output stage; list storage is not cleared.
// A stalled result holds the sequencer; input is taken only while idle.
module positional_list_engine_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [plen_pkg::IN_W-1:0]   s_axis_tdata,  // [15:0] position, [47:16] value_in
  input  logic [1:0]                  s_axis_tuser,  // [1:0] req_type
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [plen_pkg::DATA_W-1:0] m_axis_tdata,  // [31:0] value_out
  output logic [1:0]                  m_axis_tuser,  // [1:0] status
  output logic                        m_axis_tlast
);

  import plen_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_RESP,
    ST_DUMP_RD,
    ST_DUMP_OUT
  } state_e;

  state_e             state_q;
  logic [LEN_W-1:0]   len_q;
  logic [LEN_W-1:0]   cursor_q;
  logic [LEN_W-1:0]   pos_q;
  logic [DATA_W-1:0]  value_q;
  logic               is_ins_q;
  status_e            resp_q;

  logic               m_valid_q;
  logic [DATA_W-1:0]  m_data_q;
  status_e            m_status_q;
  logic               m_last_q;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;

  logic               out_free;
  logic               pos_neg;
  logic [POS_W-2:0]   pos_mag;
  logic [POS_W-2:0]   len_ext;
  logic               ins_pos_ok;
  logic               del_pos_ok;
  logic [LEN_W-1:0]   cur_inc;
  logic [LEN_W-1:0]   cur_dec;

  assign out_free   = !m_valid_q || m_axis_tready;
  assign pos_neg    = s_axis_tdata[POS_W-1];
  assign pos_mag    = s_axis_tdata[POS_W-2:0];
  assign len_ext    = {{(POS_W-1-LEN_W){1'b0}}, len_q};
  assign ins_pos_ok = !pos_neg && (pos_mag <= len_ext);
  assign del_pos_ok = !pos_neg && (pos_mag < len_ext);
  assign cur_inc    = cursor_q + LEN_W'(1);
  assign cur_dec    = cursor_q - LEN_W'(1);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;

  // RAM port control follows the sequencer state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cursor_q[IDX_W-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = cursor_q[IDX_W-1:0];
    unique case (state_q)
      ST_SHIFT_RD: begin
        ram_raddr = is_ins_q ? cur_dec[IDX_W-1:0] : cur_inc[IDX_W-1:0];
      end
      ST_SHIFT_WR: begin
        ram_we = 1'b1;
      end
      ST_PUT: begin
        ram_we    = is_ins_q;
        ram_waddr = pos_q[IDX_W-1:0];
        ram_wdata = value_q;
      end
      default: begin
      end
    endcase
  end

  plen_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_plen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      len_q      <= '0;
      cursor_q   <= '0;
      pos_q      <= '0;
      value_q    <= '0;
      is_ins_q   <= 1'b0;
      resp_q     <= STAT_OK;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      m_status_q <= STAT_OK;
      m_last_q   <= 1'b0;
    end else begin
      // the result states reload the output register themselves on a handshake
      if (m_valid_q && m_axis_tready && state_q != ST_RESP && state_q != ST_DUMP_OUT) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            pos_q   <= pos_mag[LEN_W-1:0];
            value_q <= s_axis_tdata[IN_W-1:POS_W];
            unique case (req_e'(s_axis_tuser))
              REQ_INSERT: begin
                is_ins_q <= 1'b1;
                cursor_q <= len_q;
                if (!ins_pos_ok) begin
                  resp_q  <= STAT_BADPOS;
                  state_q <= ST_RESP;
                end else if (len_q >= LEN_W'(CAPACITY)) begin
                  resp_q  <= STAT_FULL;
                  state_q <= ST_RESP;
                end else if (len_ext > pos_mag) begin
                  state_q <= ST_SHIFT_RD;
                end else begin
                  state_q <= ST_PUT;
                end
              end
              REQ_DELETE: begin
                is_ins_q <= 1'b0;
                cursor_q <= pos_mag[LEN_W-1:0];
                if (len_q == '0) begin
                  resp_q  <= STAT_EMPTY;
                  state_q <= ST_RESP;
                end else if (!del_pos_ok) begin
                  resp_q  <= STAT_BADPOS;
                  state_q <= ST_RESP;
                end else if (pos_mag + (POS_W-1)'(1) < len_ext) begin
                  state_q <= ST_SHIFT_RD;
                end else begin
                  state_q <= ST_PUT;
                end
              end
              REQ_DUMP: begin
                cursor_q <= '0;
                if (len_q == '0) begin
                  resp_q  <= STAT_EMPTY;
                  state_q <= ST_RESP;
                end else begin
                  state_q <= ST_DUMP_RD;
                end
              end
              default: begin
                // unused request code: dropped without a result
              end
            endcase
          end
        end
        ST_SHIFT_RD: begin
          state_q <= ST_SHIFT_WR;
        end
        ST_SHIFT_WR: begin
          if (is_ins_q) begin
            cursor_q <= cur_dec;
            state_q  <= (cur_dec > pos_q) ? ST_SHIFT_RD : ST_PUT;
          end else begin
            cursor_q <= cur_inc;
            state_q  <= (cur_inc + LEN_W'(1) < len_q) ? ST_SHIFT_RD : ST_PUT;
          end
        end
        ST_PUT: begin
          len_q   <= is_ins_q ? len_q + LEN_W'(1) : len_q - LEN_W'(1);
          resp_q  <= STAT_OK;
          state_q <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            m_valid_q  <= 1'b1;
            m_data_q   <= '0;
            m_status_q <= resp_q;
            m_last_q   <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        ST_DUMP_RD: begin
          state_q <= ST_DUMP_OUT;
        end
        ST_DUMP_OUT: begin
          if (out_free) begin
            m_valid_q  <= 1'b1;
            m_data_q   <= ram_rdata;
            m_status_q <= STAT_OK;
            m_last_q   <= (cur_inc == len_q);
            cursor_q   <= cur_inc;
            state_q    <= (cur_inc == len_q) ? ST_IDLE : ST_DUMP_RD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEVER(a_len_bound, clk_i, rst_ni, len_q > LEN_W'(CAPACITY),
                "list length above capacity")
  `ASSERT_PROP(a_len_step, clk_i, rst_ni,
               len_q != $past(len_q) |-> $past(state_q == ST_PUT),
               "length changed outside the commit step")
  `ASSERT_PROP(a_len_by_one, clk_i, rst_ni,
               len_q != $past(len_q) |->
                 (len_q == $past(len_q) + LEN_W'(1) || len_q + LEN_W'(1) == $past(len_q)),
               "length moved by more than one")
  `ASSERT_PROP(a_err_zero, clk_i, rst_ni,
               m_valid_q && m_status_q != STAT_OK |-> m_data_q == '0 && m_last_q,
               "error result carries data or is not last")

endmodule

### hw/rtl/plen_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module plen_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### test/positional_list_engine_core_test.sv
// Self-checking testbench for positional_list_engine_core: insert, delete and dump requests.
// It keeps a shadow copy of the list and checks every result transaction against it.
// Depends on plen_pkg and the engine RTL.
`timescale 1ns / 1ps

module positional_list_engine_core_test;
  import plen_pkg::*;

  // tuser code the engine must drop without a response
  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  // worst single request: shifting a full list or dumping it
  localparam int         TAIL_CYCLES = 2 * CAPACITY + 8;

  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] value;
    logic              last;
  } list_result_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata   = '0;  // [15:0] position, [47:16] value_in
  logic [1:0]        s_tuser   = '0;  // [1:0] req_type
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [DATA_W-1:0] m_tdata;         // [31:0] value_out
  logic [1:0]        m_tuser;         // [1:0] status
  logic              m_tlast;

  logic [DATA_W-1:0] shadow_list_q[$];
  list_result_t      pending_results_q[$];
  int                error_count   = 0;
  int                rx_hold_cycles = 0;
  bit                quiet_mode    = 1'b0;

  positional_list_engine_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic void expect_result(input status_e st, input logic [DATA_W-1:0] v,
                                        input logic l);
    list_result_t r;
    r.status = st;
    r.value  = v;
    r.last   = l;
    pending_results_q.push_back(r);
  endfunction

  // Applies one accepted request to the shadow list and queues its responses.
  function automatic void predict_list_op(input logic [1:0] req,
                                          input logic [POS_W-1:0] pos,
                                          input logic [DATA_W-1:0] val);
    bit neg;
    int idx;
    int len;
    neg = pos[POS_W-1];
    idx = pos[POS_W-2:0];
    len = shadow_list_q.size();
    case (req)
      REQ_INSERT: begin
        // position is checked before capacity
        if (neg || idx > len) begin
          expect_result(STAT_BADPOS, '0, 1'b1);
        end else if (len >= CAPACITY) begin
          expect_result(STAT_FULL, '0, 1'b1);
        end else begin
          shadow_list_q.insert(idx, val);
          expect_result(STAT_OK, '0, 1'b1);
        end
      end
      REQ_DELETE: begin
        if (len == 0) begin
          expect_result(STAT_EMPTY, '0, 1'b1);
        end else if (neg || idx >= len) begin
          expect_result(STAT_BADPOS, '0, 1'b1);
        end else begin
          shadow_list_q.delete(idx);
          expect_result(STAT_OK, '0, 1'b1);
        end
      end
      REQ_DUMP: begin
        if (len == 0) begin
          expect_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (int k = 0; k < len; k++) begin
            expect_result(STAT_OK, shadow_list_q[k], k == len - 1);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Offers one request and returns at the edge where it is accepted; tvalid stays high.
  task automatic push_request(input logic [1:0] req, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] val);
    int gap;
    @(negedge clk);
    if (!quiet_mode && $urandom_range(0, 99) < 10) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {val, pos};
    s_tuser  <= req;
    do @(posedge clk); while (!s_tready);
    predict_list_op(req, pos, val);
  endtask

  task automatic wait_results_drained(input int tail);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results_q.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles--;
      m_tready <= 1'b0;
    end else if (!quiet_mode && $urandom_range(0, 99) < 10) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (pending_results_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result status %0d value %h last %b",
                                m_tuser, m_tdata, m_tlast));
      end else begin
        want = pending_results_q.pop_front();
        if (m_tuser !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
        if (m_tdata !== want.value)
          flag_mismatch($sformatf("value %h, want %h", m_tdata, want.value));
        if (m_tlast !== want.last)
          flag_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
      end
    end
  end

  task automatic test_directed_edges();
    push_request(REQ_DUMP, 16'($urandom), $urandom);       // dump of empty list
    push_request(REQ_DELETE, 16'h0000, $urandom);          // delete from empty list
    push_request(REQ_DELETE, 16'h8000, $urandom);          // empty wins over bad position
    push_request(REQ_INSERT, 16'h8000, 32'h0000_0000);     // most negative position
    push_request(REQ_INSERT, 16'h7fff, 32'hffff_ffff);     // far past the end
    push_request(REQ_INSERT, 16'h0001, $urandom);          // one past the end
    push_request(REQ_INSERT, 16'h0000, 32'h7fff_ffff);
    push_request(REQ_INSERT, 16'h0000, 32'h8000_0000);     // at head
    push_request(REQ_INSERT, 16'h0002, 32'h0000_0000);     // at tail
    push_request(REQ_INSERT, 16'h0001, 32'hffff_ffff);     // in the middle
    push_request(REQ_INSERT, 16'hffff, $urandom);          // minus one
    push_request(REQ_DUMP, 16'($urandom), $urandom);
    push_request(REQ_DELETE, 16'h0004, $urandom);          // position equal to length
    push_request(REQ_DELETE, 16'hffff, $urandom);
    push_request(REQ_DELETE, 16'h7fff, $urandom);
    push_request(REQ_UNUSED, 16'($urandom), $urandom);     // dropped silently
    push_request(REQ_DELETE, 16'h0003, $urandom);          // tail
    push_request(REQ_DELETE, 16'h0000, $urandom);          // head
    push_request(REQ_DUMP, 16'($urandom), $urandom);
    push_request(REQ_DELETE, 16'h0000, $urandom);
    push_request(REQ_DELETE, 16'h0000, $urandom);
    push_request(REQ_DUMP, 16'($urandom), $urandom);
    wait_results_drained(0);
  endtask

  // Receiver stalls for a long stretch while the list is filled to capacity.
  task automatic test_full_list_backpressure();
    int len;
    @(posedge clk);
    rx_hold_cycles = 400;
    while (shadow_list_q.size() < CAPACITY) begin
      len = shadow_list_q.size();
      push_request(REQ_INSERT, 16'($urandom_range(0, len)), $urandom);
    end
    push_request(REQ_INSERT, 16'($urandom_range(0, CAPACITY)), $urandom);  // full
    push_request(REQ_INSERT, 16'(CAPACITY + 1), $urandom);                 // bad position first
    push_request(REQ_INSERT, {1'b1, 15'($urandom)}, $urandom);
    push_request(REQ_DUMP, 16'($urandom), $urandom);
    push_request(REQ_DELETE, 16'(CAPACITY - 1), $urandom);
    push_request(REQ_DELETE, 16'h0000, $urandom);
    push_request(REQ_DUMP, 16'($urandom), $urandom);
    // sender holds until all responses are back
    wait_results_drained(0);
  endtask

  task automatic test_random_walk(input int n_items);
    int         len;
    int         r;
    bit         grow;
    logic [1:0] req;
    grow = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 4) quiet_mode = 1'b1;
      if (i == n_items / 2) begin
        quiet_mode = 1'b0;
        wait_results_drained(0);
      end
      len = shadow_list_q.size();
      if (len >= CAPACITY) grow = 1'b0;
      else if (len == 0) grow = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_request(REQ_DUMP, 16'($urandom), $urandom);
      end else if (r < 12) begin
        push_request(REQ_UNUSED, 16'($urandom), $urandom);
      end else if (r < 22) begin
        req = $urandom_range(0, 1) ? REQ_INSERT : REQ_DELETE;
        if ($urandom_range(0, 1))
          push_request(req, {1'b1, 15'($urandom)}, $urandom);
        else if (req == REQ_INSERT)
          push_request(req, 16'($urandom_range(len + 1, 32767)), $urandom);
        else
          push_request(req, 16'($urandom_range(len, 32767)), $urandom);
      end else if ($urandom_range(0, 99) < (grow ? 80 : 20)) begin
        push_request(REQ_INSERT, 16'($urandom_range(0, len)), $urandom);
      end else begin
        push_request(REQ_DELETE, 16'($urandom_range(0, (len > 0) ? len - 1 : 0)), $urandom);
      end
    end
    wait_results_drained(0);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_directed_edges();
    test_full_list_backpressure();
    test_random_walk(49);
    wait_results_drained(TAIL_CYCLES);
    if (error_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
